// ----- hw/rtl/rsks_pkg.sv -----
// Shared constants and control types for the k-smallest running-sum selector.
// No dependencies; imported by every module of the block.
package rsks_pkg;

  localparam int HEAP_DEPTH = 1024;
  localparam int IDX_W      = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int KEEP_W     = 11;
  localparam int CMP_W      = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;
  localparam int COST_W     = 32;
  localparam int SUM_W      = 43;
  localparam int OUT_SUM_W  = 42;
  localparam int APB_DW     = 32;
  localparam int PADDR_W    = 2;

  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(1);

  typedef struct packed {
    logic load;       // item accepted this cycle
    logic up_step;    // one sift-up level
    logic down_step;  // one sift-down level
    logic rd_up;      // next reads fetch the parent rather than the children
  } rsks_cmd_t;

  typedef struct packed {
    logic start_up;   // accepted item needs a sift-up pass
    logic start_down; // accepted item replaces the top and sifts down
    logic up_move;    // sift-up continues after this level
    logic down_move;  // sift-down continues after this level
  } rsks_sts_t;

endpackage

// ----- hw/rtl/running_sum_of_k_smallest_top.sv -----
// Latency: the result of an item is offered the cycle after it is accepted.
// Acceptance: a new item is taken while no sift is running and no result is
// held by out_stall; an insertion then runs the sift-up loop (one heap level per
// cycle), a top replacement the sift-down loop (two reads).
// Reset (rst_n low, synchronous): heap empty, sum zero, keep_count = 1;
// no clearing pass, items are taken the cycle after reset is released.
module running_sum_of_k_smallest_top
  import rsks_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_restart,
  input  logic [COST_W-1:0]    in_cost,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_SUM_W-1:0] out_smallest_sum,
  output logic                 out_full_res,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready
);

  localparam logic [PADDR_W-1:0] REG_KEEP_COUNT = '0;

  logic [KEEP_W-1:0] keep_count_r;
  logic              keep_wr;
  rsks_cmd_t         cmd;
  rsks_sts_t         sts;

  assign pready  = 1'b1;
  assign keep_wr = psel & penable & pwrite & pready & ((paddr >> 2) == REG_KEEP_COUNT);
  assign prdata  = APB_DW'(keep_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_count_r <= KEEP_RESET;
    end else if (keep_wr) begin
      keep_count_r <= pwdata[KEEP_W-1:0];
    end
  end

  rsks_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rsks_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_restart       (in_restart),
    .in_cost          (in_cost),
    .keep_count       (keep_count_r),
    .out_smallest_sum (out_smallest_sum),
    .out_full_res     (out_full_res)
  );

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted item gave no result");

  a_one_activity: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.up_step, cmd.down_step}))
    else $error("load and sift steps overlap");

  a_replace_sifts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && sts.start_down) |=> cmd.down_step)
    else $error("top replacement did not start sift-down");

  a_insert_sifts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && sts.start_up) |=> cmd.up_step)
    else $error("insertion did not start sift-up");

endmodule

// ----- hw/rtl/rsks_ctrl.sv -----
// Controller for the k-smallest selector: item handshake, result valid and
// sift sequencing. Depends on rsks_pkg.
module rsks_ctrl
  import rsks_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  rsks_sts_t sts,
  output rsks_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UP   = 2'd1;
  localparam logic [1:0] ST_DOWN = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    in_stall      = (state_r != ST_IDLE) | (out_valid_r & out_stall);
    cmd.load      = in_valid & ~in_stall;
    cmd.up_step   = (state_r == ST_UP);
    cmd.down_step = (state_r == ST_DOWN);
    cmd.rd_up     = (state_r == ST_UP) | (cmd.load & sts.start_up);
    out_valid_nxt = cmd.load | (out_valid_r & out_stall);
    state_nxt     = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.load && sts.start_up) begin
          state_nxt = ST_UP;
        end else if (cmd.load && sts.start_down) begin
          state_nxt = ST_DOWN;
        end
      end
      ST_UP: begin
        if (!sts.up_move) state_nxt = ST_IDLE;
      end
      ST_DOWN: begin
        if (!sts.down_move) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hw/rtl/rsks_dp.sv -----
// Datapath for the k-smallest selector: heap memory, held count, running sum
// and result registers. Depends on rsks_pkg; driven by rsks_ctrl.
module rsks_dp
  import rsks_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  rsks_cmd_t            cmd,
  output rsks_sts_t            sts,
  input  logic                 in_restart,
  input  logic [COST_W-1:0]    in_cost,
  input  logic [KEEP_W-1:0]    keep_count,
  output logic [OUT_SUM_W-1:0] out_smallest_sum,
  output logic                 out_full_res
);

  logic [COST_W-1:0] heap_mem [HEAP_DEPTH];

  logic [CNT_W-1:0]     held_r, held_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [COST_W-1:0]    top_r;
  logic [IDX_W-1:0]     pos_r, pos_nxt;
  logic [COST_W-1:0]    val_r;
  logic [COST_W-1:0]    rd_a_r, rd_b_r;
  logic [OUT_SUM_W-1:0] osum_r;
  logic                 ofull_r;

  logic [CMP_W-1:0]   k_eff;
  logic [CNT_W-1:0]   held_eff;
  logic [SUM_W-1:0]   sum_eff;
  logic               full;
  logic               insert_root;
  logic [IDX_W-1:0]   pos_dec, parent;
  logic [IDX_W+1:0]   lc_w, rc_w;
  logic               take_l, take_r;
  logic [COST_W-1:0]  best_v;
  logic [IDX_W-1:0]   np_dec, ra, rb;
  logic [IDX_W+1:0]   nlc, nrc;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [COST_W-1:0]  wdata;

  always_comb begin
    k_eff = (CMP_W'(keep_count) > CMP_W'(HEAP_DEPTH)) ? CMP_W'(HEAP_DEPTH)
                                                      : CMP_W'(keep_count);
    held_eff = in_restart ? '0 : held_r;
    sum_eff  = in_restart ? '0 : sum_r;
    full     = (CMP_W'(held_eff) >= k_eff);
    insert_root    = ~full & (held_eff == '0);
    sts.start_up   = ~full & (held_eff != '0);
    sts.start_down = full & (held_eff != '0) & (in_cost < top_r);

    pos_dec = pos_r - IDX_W'(1);
    parent  = pos_dec >> 1;
    sts.up_move = (pos_r != '0) & (rd_a_r < val_r);

    lc_w   = {1'b0, pos_r, 1'b1};
    rc_w   = lc_w + (IDX_W+2)'(1);
    take_l = (lc_w < (IDX_W+2)'(held_r)) & (rd_a_r > val_r);
    best_v = take_l ? rd_a_r : val_r;
    take_r = (rc_w < (IDX_W+2)'(held_r)) & (rd_b_r > best_v);
    sts.down_move = take_l | take_r;

    we       = 1'b0;
    waddr    = pos_r;
    wdata    = val_r;
    pos_nxt  = pos_r;
    held_nxt = held_r;
    sum_nxt  = sum_r;
    if (cmd.load) begin
      held_nxt = full ? held_eff : held_eff + CNT_W'(1);
      sum_nxt  = sum_eff;
      if (!full) begin
        sum_nxt = sum_eff + SUM_W'(in_cost);
      end else if (sts.start_down) begin
        sum_nxt = sum_eff - SUM_W'(top_r) + SUM_W'(in_cost);
      end
      pos_nxt = sts.start_up ? held_eff[IDX_W-1:0] : '0;
      if (insert_root) begin
        we    = 1'b1;
        waddr = '0;
        wdata = in_cost;
      end
    end
    if (cmd.up_step) begin
      we = 1'b1;
      if (sts.up_move) begin
        wdata   = rd_a_r;
        pos_nxt = parent;
      end
    end
    if (cmd.down_step) begin
      we = 1'b1;
      if (take_r) begin
        wdata   = rd_b_r;
        pos_nxt = rc_w[IDX_W-1:0];
      end else if (take_l) begin
        wdata   = rd_a_r;
        pos_nxt = lc_w[IDX_W-1:0];
      end
    end

    np_dec = pos_nxt - IDX_W'(1);
    nlc    = {1'b0, pos_nxt, 1'b1};
    nrc    = nlc + (IDX_W+2)'(1);
    ra     = cmd.rd_up ? (np_dec >> 1) : nlc[IDX_W-1:0];
    rb     = nrc[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (we) heap_mem[waddr] <= wdata;
    rd_a_r <= heap_mem[ra];
    rd_b_r <= heap_mem[rb];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      sum_r  <= '0;
    end else begin
      held_r <= held_nxt;
      sum_r  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (we && waddr == '0) top_r <= wdata;
    if (cmd.load) begin
      val_r   <= in_cost;
      osum_r  <= sum_eff[OUT_SUM_W-1:0];
      ofull_r <= full;
    end
  end

  assign out_smallest_sum = osum_r;
  assign out_full_res     = ofull_r;

endmodule
